### sv/linked_multi_queue_with_join_defines.svh
// Assertion macros for the linked multi-queue block.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef LINKED_MULTI_QUEUE_WITH_JOIN_DEFINES_SVH
`define LINKED_MULTI_QUEUE_WITH_JOIN_DEFINES_SVH

// Checks a property on every clock edge outside of reset.
`define LMQJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on every clock edge, reset included.
`define LMQJ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### sv/lmqj_pkg.sv
// Shared types and constants for the linked multi-queue block.
// No dependencies; used by the channel interfaces and the top level.
package lmqj_pkg;

  // Sizes of the queue table and the node pool.
  localparam int unsigned QUEUE_COUNT = 16;
  localparam int unsigned POOL_DEPTH  = 1024;
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned QIDX_W = $clog2(QUEUE_COUNT);
  localparam int unsigned PTR_W  = $clog2(POOL_DEPTH);
  localparam int unsigned LEN_W  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned STAT_W = 2;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_JOIN   = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Request beat.
  typedef struct packed {
    logic [ACT_W-1:0]       action;
    logic [QIDX_W-1:0]      target_queue;
    logic [QIDX_W-1:0]      source_queue;
    logic [VALUE_WIDTH-1:0] item_value;
  } lmqj_req_t;

  // Response beat.
  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic [VALUE_WIDTH-1:0] removed_value;
    logic [LEN_W-1:0]       target_length;
  } lmqj_rsp_t;

endpackage

### sv/lmqj_req_if.sv
// Request channel of the linked multi-queue block.
// Depends on lmqj_pkg for the request beat type.
interface lmqj_req_if import lmqj_pkg::*; ();
  logic      valid;
  logic      ready;
  lmqj_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/lmqj_rsp_if.sv
// Response channel of the linked multi-queue block.
// Depends on lmqj_pkg for the response beat type.
interface lmqj_rsp_if import lmqj_pkg::*; ();
  logic      valid;
  logic      ready;
  lmqj_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/linked_multi_queue_with_join.sv
// Sixteen FIFO queues share a pool of 1024 linked nodes; each request beat appends a
// value, removes a queue head, or joins a whole source queue onto a destination tail,
// and yields exactly one response beat. The block takes one request at a time: an
// append or a remove goes from decode to its update state, a join from decode to
// the source snapshot and the destination update, and a dropped append, a remove
// from an empty queue, a self join or an unused code ends in decode. The update state
// follows the registered read of the node link memory (and item memory) through a
// single read port; a join needs the snapshot since the table is read at one queue
// per cycle. A request is taken while the prior response still waits in the output
// register; it only stalls if a second response is ready before the first one left.
// Depends on lmqj_pkg, lmqj_req_if, lmqj_rsp_if and the assertion macro header.
`include "linked_multi_queue_with_join_defines.svh"

module linked_multi_queue_with_join import lmqj_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  lmqj_req_if.sink   req_i,
  lmqj_rsp_if.source rsp_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_APP  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_JSRC = 3'd4;
  localparam logic [2:0] S_JDST = 3'd5;

  localparam logic [LEN_W-1:0] POOL_FULL = LEN_W'(POOL_DEPTH);
  localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

  logic [2:0] state_q, state_d;

  // Captured request.
  logic [ACT_W-1:0]       act_q;
  logic [QIDX_W-1:0]      tq_q, sq_q;
  logic [VALUE_WIDTH-1:0] val_q;

  // Queue table.
  logic [PTR_W-1:0] head_q [QUEUE_COUNT];
  logic [PTR_W-1:0] tail_q [QUEUE_COUNT];
  logic [LEN_W-1:0] len_q  [QUEUE_COUNT];

  // Free list and fresh node counter.
  logic [PTR_W-1:0] free_head_q, free_head_d;
  logic [LEN_W-1:0] free_len_q, free_len_d;
  logic [LEN_W-1:0] fresh_q, fresh_d;

  // Join source snapshot.
  logic [PTR_W-1:0] src_head_q, src_tail_q;
  logic [LEN_W-1:0] src_len_q;
  logic             src_cap;

  // Node memories.
  logic [PTR_W-1:0]       link_mem [POOL_DEPTH];
  logic [VALUE_WIDTH-1:0] item_mem [POOL_DEPTH];
  logic [PTR_W-1:0]       link_rdata_q;
  logic [VALUE_WIDTH-1:0] item_rdata_q;
  logic                   link_we, link_re, item_we, item_re;
  logic [PTR_W-1:0]       link_waddr, link_wdata, mem_raddr, item_waddr;

  // Queue table write controls.
  logic             head_we, tail_we, len_we, src_clr;
  logic [PTR_W-1:0] head_wdata, tail_wdata;
  logic [LEN_W-1:0] len_wdata;

  // Output register.
  logic      out_valid_q;
  lmqj_rsp_t out_q, res;
  logic      fin, fin_ok;

  // Table read port: the join source in S_JSRC, the target otherwise.
  logic [QIDX_W-1:0] tbl_idx;
  logic [PTR_W-1:0]  head_t, tail_t, node_sel;
  logic [LEN_W-1:0]  len_t;

  assign tbl_idx  = (state_q == S_JSRC) ? sq_q : tq_q;
  assign head_t   = head_q[tbl_idx];
  assign tail_t   = tail_q[tbl_idx];
  assign len_t    = len_q[tbl_idx];
  assign node_sel = (free_len_q != '0) ? free_head_q : fresh_q[PTR_W-1:0];
  assign fin_ok   = !out_valid_q || rsp_o.ready;

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // Sequencer and datapath control.
  always_comb begin
    state_d     = state_q;
    fin         = 1'b0;
    res         = '{status: STAT_OK, removed_value: '0, target_length: len_t};
    free_head_d = free_head_q;
    free_len_d  = free_len_q;
    fresh_d     = fresh_q;
    src_cap     = 1'b0;
    link_we     = 1'b0;
    link_re     = 1'b0;
    item_we     = 1'b0;
    item_re     = 1'b0;
    link_waddr  = tail_t;
    link_wdata  = node_sel;
    mem_raddr   = head_t;
    item_waddr  = node_sel;
    head_we     = 1'b0;
    tail_we     = 1'b0;
    len_we      = 1'b0;
    src_clr     = 1'b0;
    head_wdata  = node_sel;
    tail_wdata  = node_sel;
    len_wdata   = len_t;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        case (act_q)
          ACT_APPEND: begin
            if (free_len_q != '0) begin
              // Fetch the link after the free head for the pop.
              link_re   = 1'b1;
              mem_raddr = free_head_q;
              state_d   = S_APP;
            end else if (fresh_q != POOL_FULL) begin
              state_d = S_APP;
            end else begin
              fin        = 1'b1;
              res.status = STAT_FULL;
              if (fin_ok) begin
                state_d = S_IDLE;
              end
            end
          end
          ACT_REMOVE: begin
            if (len_t == '0) begin
              fin        = 1'b1;
              res.status = STAT_EMPTY;
              if (fin_ok) begin
                state_d = S_IDLE;
              end
            end else begin
              link_re   = 1'b1;
              item_re   = 1'b1;
              mem_raddr = head_t;
              state_d   = S_REM;
            end
          end
          ACT_JOIN: begin
            if (tq_q == sq_q) begin
              fin = 1'b1;
              if (fin_ok) begin
                state_d = S_IDLE;
              end
            end else begin
              state_d = S_JSRC;
            end
          end
          default: begin
            fin = 1'b1;
            if (fin_ok) begin
              state_d = S_IDLE;
            end
          end
        endcase
      end
      S_APP: begin
        fin               = 1'b1;
        res.target_length = len_t + LEN_ONE;
        if (fin_ok) begin
          state_d   = S_IDLE;
          item_we   = 1'b1;
          link_we   = (len_t != '0);
          head_we   = (len_t == '0);
          tail_we   = 1'b1;
          len_we    = 1'b1;
          len_wdata = len_t + LEN_ONE;
          if (free_len_q != '0) begin
            free_len_d = free_len_q - LEN_ONE;
            if (free_len_q > LEN_ONE) begin
              free_head_d = link_rdata_q;
            end
          end else begin
            fresh_d = fresh_q + LEN_ONE;
          end
        end
      end
      S_REM: begin
        fin               = 1'b1;
        res.removed_value = item_rdata_q;
        res.target_length = len_t - LEN_ONE;
        if (fin_ok) begin
          state_d    = S_IDLE;
          head_we    = (len_t > LEN_ONE);
          head_wdata = link_rdata_q;
          len_we     = 1'b1;
          len_wdata  = len_t - LEN_ONE;
          // Push the freed node onto the free list.
          link_we     = 1'b1;
          link_waddr  = head_t;
          link_wdata  = free_head_q;
          free_head_d = head_t;
          free_len_d  = free_len_q + LEN_ONE;
        end
      end
      S_JSRC: begin
        src_cap = 1'b1;
        state_d = S_JDST;
      end
      S_JDST: begin
        fin               = 1'b1;
        res.target_length = len_t + src_len_q;
        if (fin_ok) begin
          state_d = S_IDLE;
          if (src_len_q != '0) begin
            head_we    = (len_t == '0);
            head_wdata = src_head_q;
            link_we    = (len_t != '0);
            link_wdata = src_head_q;
            tail_we    = 1'b1;
            tail_wdata = src_tail_q;
            len_we     = 1'b1;
            len_wdata  = len_t + src_len_q;
            src_clr    = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and queue table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      free_len_q  <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        len_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      free_len_q  <= free_len_d;
      fresh_q     <= fresh_d;
      if (fin && fin_ok) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (head_we) begin
        head_q[tq_q] <= head_wdata;
      end
      if (tail_we) begin
        tail_q[tq_q] <= tail_wdata;
      end
      if (len_we) begin
        len_q[tq_q] <= len_wdata;
      end
      if (src_clr) begin
        len_q[sq_q] <= '0;
      end
    end
  end

  // Payload registers: request capture, join snapshot, response.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      act_q <= req_i.payload.action;
      tq_q  <= req_i.payload.target_queue;
      sq_q  <= req_i.payload.source_queue;
      val_q <= req_i.payload.item_value;
    end
    if (src_cap) begin
      src_head_q <= head_t;
      src_tail_q <= tail_t;
      src_len_q  <= len_t;
    end
    if (fin && fin_ok) begin
      out_q <= res;
    end
  end

  // Node link memory.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata_q <= link_mem[mem_raddr];
    end
  end

  // Node item memory.
  always_ff @(posedge clk_i) begin
    if (item_we) begin
      item_mem[item_waddr] <= val_q;
    end
    if (item_re) begin
      item_rdata_q <= item_mem[mem_raddr];
    end
  end

  // The fresh counter never passes the pool size.
  `LMQJ_ASSERT(a_fresh_bound, fresh_q <= POOL_FULL, "fresh node counter beyond pool")
  // Every free node was handed out fresh once.
  `LMQJ_ASSERT(a_free_le_fresh, free_len_q <= fresh_q, "free list longer than nodes used")
  // An accepted beat is decoded in the next cycle.
  `LMQJ_ASSERT(a_accept_dec, req_i.valid && req_i.ready |=> state_q == S_DEC,
               "accepted request not decoded")
  // A remove only reaches its update with a non-empty queue.
  `LMQJ_ASSERT(a_rem_nonempty, state_q == S_REM |-> len_t != '0, "remove from empty queue")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for linked_multi_queue_with_join: drives request beats,
// predicts every response with a shadow copy of the queues and the node pool.
// Depends on lmqj_pkg, lmqj_req_if, lmqj_rsp_if and the block itself.
module tb;
  import lmqj_pkg::*;

  // Action code that the block must treat as a no-op.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  // Depth of the ring that holds the responses still owed.
  localparam int unsigned OWED_DEPTH = 16;

  // Shadow of the queue table and node pool; holds the responses still owed.
  class queue_pool_tracker;
    bit [PTR_W-1:0]       head_ptr[QUEUE_COUNT];
    bit [PTR_W-1:0]       tail_ptr[QUEUE_COUNT];
    bit [LEN_W-1:0]       qlen[QUEUE_COUNT];
    bit [PTR_W-1:0]       link_mem[POOL_DEPTH];
    bit [VALUE_WIDTH-1:0] value_mem[POOL_DEPTH];
    bit [PTR_W-1:0]       free_top;
    int unsigned          free_count;
    int unsigned          fresh_next;
    lmqj_rsp_t            owed_ring[OWED_DEPTH];
    int unsigned          owed_wr;
    int unsigned          owed_rd;
    int unsigned          errors;
    int unsigned          checked, appends_ok, full_drops, removes_ok, empty_removes;
    int unsigned          joins_moved, joins_noop, unused_codes, reused_nodes;

    function int unsigned nodes_in_use();
      return fresh_next - free_count;
    endfunction

    function int unsigned pending();
      return owed_wr - owed_rd;
    endfunction

    // A random queue that holds items, or any queue when all are empty.
    function bit [QIDX_W-1:0] random_busy_queue();
      bit [QIDX_W-1:0] busy[QUEUE_COUNT];
      int unsigned     n_busy;
      n_busy = 0;
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        if (qlen[q] != 0) begin
          busy[n_busy] = QIDX_W'(q);
          n_busy++;
        end
      end
      if (n_busy == 0) return QIDX_W'($urandom_range(QUEUE_COUNT - 1));
      return busy[$urandom_range(n_busy - 1)];
    endfunction

    // Freed nodes come back first; untouched nodes after that.
    function bit grab_node(output bit [PTR_W-1:0] node);
      if (free_count > 0) begin
        node = free_top;
        if (free_count > 1) free_top = link_mem[free_top];
        free_count--;
        reused_nodes++;
        return 1'b1;
      end
      if (fresh_next < POOL_DEPTH) begin
        node = PTR_W'(fresh_next);
        fresh_next++;
        return 1'b1;
      end
      node = '0;
      return 1'b0;
    endfunction

    // Applies one accepted request beat and queues the response it must produce.
    function void note_request(lmqj_req_t r);
      lmqj_rsp_t       exp_rsp;
      bit [QIDX_W-1:0] tq;
      bit [QIDX_W-1:0] sq;
      bit [PTR_W-1:0]  node;
      exp_rsp = '0;
      tq = r.target_queue;
      sq = r.source_queue;
      case (r.action)
        ACT_APPEND: begin
          if (grab_node(node)) begin
            value_mem[node] = r.item_value;
            if (qlen[tq] == 0) head_ptr[tq] = node;
            else link_mem[tail_ptr[tq]] = node;
            tail_ptr[tq] = node;
            qlen[tq]++;
            appends_ok++;
          end else begin
            exp_rsp.status = STAT_FULL;
            full_drops++;
          end
        end
        ACT_REMOVE: begin
          if (qlen[tq] == 0) begin
            exp_rsp.status = STAT_EMPTY;
            empty_removes++;
          end else begin
            node = head_ptr[tq];
            exp_rsp.removed_value = value_mem[node];
            if (qlen[tq] > 1) head_ptr[tq] = link_mem[node];
            qlen[tq]--;
            // The freed node goes on top of the free list.
            link_mem[node] = free_top;
            free_top = node;
            free_count++;
            removes_ok++;
          end
        end
        ACT_JOIN: begin
          if (tq != sq && qlen[sq] != 0) begin
            if (qlen[tq] == 0) head_ptr[tq] = head_ptr[sq];
            else link_mem[tail_ptr[tq]] = head_ptr[sq];
            tail_ptr[tq] = tail_ptr[sq];
            qlen[tq] += qlen[sq];
            qlen[sq] = 0;
            joins_moved++;
          end else begin
            joins_noop++;
          end
        end
        default: unused_codes++;
      endcase
      exp_rsp.target_length = qlen[tq];
      owed_ring[owed_wr % OWED_DEPTH] = exp_rsp;
      owed_wr++;
    endfunction

    // Compares one accepted response beat with the oldest owed response.
    function void check_response(lmqj_rsp_t got);
      lmqj_rsp_t want;
      if (pending() == 0) begin
        $error("response beat with no request outstanding");
        errors++;
        return;
      end
      want = owed_ring[owed_rd % OWED_DEPTH];
      owed_rd++;
      checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.removed_value !== want.removed_value) begin
        $error("removed_value: expected 0x%08h, actual 0x%08h",
               want.removed_value, got.removed_value);
        errors++;
      end
      if (got.target_length !== want.target_length) begin
        $error("target_length: expected %0d, actual %0d",
               want.target_length, got.target_length);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  queue_pool_tracker tracker;

  lmqj_req_if req_bus ();
  lmqj_rsp_if rsp_bus ();

  linked_multi_queue_with_join DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Free-running clock, 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #400us;
    $display("linked_multi_queue_with_join regression: fail");
    $finish;
  end

  // Response ready, stalled at random from the falling edge.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_bus.ready = rst_ni && ($urandom_range(99) >= stall_pct);
    end
  end

  // Every response beat is checked at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) tracker.check_response(rsp_bus.payload);
  end

  // Offers one request beat, with random idle cycles first, and holds it until taken.
  task automatic send_beat(lmqj_req_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid   = 1'b1;
    req_bus.payload = beat;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    tracker.note_request(beat);
    @(negedge clk_i);
  endtask

  task automatic issue(logic [ACT_W-1:0] act, int unsigned tq, int unsigned sq,
                       logic [VALUE_WIDTH-1:0] val);
    lmqj_req_t beat;
    beat.action       = act;
    beat.target_queue = QIDX_W'(tq);
    beat.source_queue = QIDX_W'(sq);
    beat.item_value   = val;
    send_beat(beat);
  endtask

  // Holds the request side until every owed response has come back.
  task automatic drain_responses();
    req_bus.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  // Short directed sequence over the corner cases of each action.
  task automatic run_directed();
    issue(ACT_REMOVE, 0, 0, 32'h0);            // remove from an empty queue
    issue(ACT_APPEND, 0, 9, 32'h0000_0000);
    issue(ACT_APPEND, 0, 6, 32'hFFFF_FFFF);
    issue(ACT_APPEND, 15, 0, 32'hA5A5_A5A5);
    issue(ACT_JOIN, 0, 0, 32'h1);              // join of a queue with itself
    issue(ACT_JOIN, 0, 3, 32'h2);              // empty source
    issue(ACT_JOIN, 5, 0, 32'h3);              // empty target takes the source over
    issue(ACT_JOIN, 5, 15, 32'h4);             // non-empty onto non-empty
    issue(ACT_UNUSED, 5, 15, 32'hFFFF_FFFF);
    issue(ACT_REMOVE, 0, 0, 32'h0);            // source of a join is empty now
    issue(ACT_REMOVE, 5, 15, 32'hFFFF_FFFF);
    issue(ACT_REMOVE, 5, 0, 32'h0);
    issue(ACT_APPEND, 5, 0, 32'h5A5A_5A5A);    // reuses freed nodes
    issue(ACT_APPEND, 5, 15, 32'h1234_5678);
    issue(ACT_APPEND, 10, 15, 32'h8000_0001);
    issue(ACT_REMOVE, 5, 0, 32'h0);
    issue(ACT_REMOVE, 5, 0, 32'h0);
    issue(ACT_REMOVE, 5, 0, 32'h0);
    issue(ACT_REMOVE, 5, 0, 32'h0);            // emptied queue with stale pointers
    issue(ACT_JOIN, 5, 10, 32'h0);             // onto the emptied queue
    issue(ACT_UNUSED, 0, 0, 32'h0);
    issue(ACT_REMOVE, 5, 10, 32'h0);
  endtask

  // Random beat; the fill mix pushes the pool to exhaustion, the drain mix frees it.
  function automatic lmqj_req_t random_request(bit filling);
    lmqj_req_t   beat;
    int unsigned roll;
    roll = $urandom_range(99);
    beat.target_queue = QIDX_W'($urandom_range(QUEUE_COUNT - 1));
    beat.source_queue = QIDX_W'($urandom_range(QUEUE_COUNT - 1));
    beat.item_value   = $urandom;
    if (roll < (filling ? 94 : 15)) begin
      beat.action = ACT_APPEND;
    end else if (roll < (filling ? 97 : 25)) begin
      beat.action = ACT_JOIN;
      if ($urandom_range(3) != 0) beat.source_queue = tracker.random_busy_queue();
    end else if (roll < (filling ? 99 : 96)) begin
      beat.action = ACT_REMOVE;
      if ($urandom_range(4) != 0) beat.target_queue = tracker.random_busy_queue();
    end else begin
      beat.action = ACT_UNUSED;
    end
    return beat;
  endfunction

  // Reset, directed part, four idling phases of random traffic, then the verdict.
  initial begin
    int unsigned idle_mix[4][2];
    bit          filling;
    tracker         = new;
    idle_mix        = '{'{0, 0}, '{79, 0}, '{0, 79}, '{31, 31}};
    send_idle_pct   = 0;
    stall_pct       = 0;
    req_bus.valid   = 1'b0;
    req_bus.payload = '0;
    rst_ni          = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    drain_responses();

    filling = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_mix[phase][0];
      stall_pct     = idle_mix[phase][1];
      for (int n = 0; n < 300; n++) begin
        if (filling && tracker.nodes_in_use() == POOL_DEPTH && tracker.full_drops >= 8)
          filling = 1'b0;
        else if (!filling && tracker.nodes_in_use() < POOL_DEPTH / 2)
          filling = 1'b1;
        if (phase == 2 && n == 150) drain_responses();
        send_beat(random_request(filling));
      end
    end

    drain_responses();
    repeat (20) @(posedge clk_i);

    $display("Checked %0d responses: %0d appends, %0d dropped on a full pool, %0d removes,",
             tracker.checked, tracker.appends_ok, tracker.full_drops, tracker.removes_ok);
    $display("%0d removes from empty queues, %0d joins moved, %0d no-op joins,",
             tracker.empty_removes, tracker.joins_moved, tracker.joins_noop);
    $display("%0d unused codes, %0d nodes reused.",
             tracker.unused_codes, tracker.reused_nodes);
    if (tracker.errors == 0) begin
      $display("linked_multi_queue_with_join regression: pass");
    end else begin
      $display("linked_multi_queue_with_join regression: fail");
    end
    $finish;
  end

endmodule
